// ----- sv/hwt_pkg.sv -----
// ----------------------------------------------------------------------------
// Hashed timing wheel package
// Shared widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package hwt_pkg;

    localparam int MAX_EVENTS_DEF = 16;
    localparam int ID_MAX         = 16;
    localparam int ID_W           = 4;
    localparam int SLOT_W         = 16;
    localparam int ROUND_W        = 32;
    localparam int DELAY_W        = 24;
    localparam int DIV_W          = 25;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 1;

    localparam logic [1:0] FUNC_REG    = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;

    localparam logic [1:0] KIND_REG    = 2'd0;
    localparam logic [1:0] KIND_FIRE   = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_STOP     = 3'd3;
    localparam logic [2:0] ST_INACTIVE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_DIV,
        S_EMIT,
        S_SCAN
    } t_state;

    typedef enum logic [2:0] {
        RP_REG_OK,
        RP_FULL,
        RP_ZERO,
        RP_STOP,
        RP_QUIET,
        RP_CAN_OK,
        RP_CAN_BAD
    } t_reply;

    typedef struct packed {
        logic   latch_in;
        logic   div_start;
        logic   div_tick;
        logic   commit;
        logic   commit_alloc;
        logic   cancel_clr;
        logic   load_mask;
        logic   fire;
        logic   emit_reply;
        t_reply reply;
        logic   advance;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       zero_int;
        logic       full;
        logic       stopped;
        logic       cancel_ok;
        logic       mask_empty;
        logic       scan_repeat;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

// ----- sv/hwt_div.sv -----
// ----------------------------------------------------------------------------
// Hashed timing wheel divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hwt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hwt_pkg::DIV_W-1:0]   i_dividend,
    input  logic [hwt_pkg::SLOT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [hwt_pkg::DIV_W-1:0]   o_quot,
    output logic [hwt_pkg::SLOT_W-1:0]  o_rem
);
    localparam int DW   = hwt_pkg::DIV_W;
    localparam int SW   = hwt_pkg::SLOT_W;
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]   r_quot, n_quot;
    logic [SW-1:0]   r_rem, n_rem;
    logic [SW-1:0]   r_div, n_div;
    logic [SW:0]     rem_sh;
    logic [SW:0]     diff;
    logic            ge;

    always_comb begin
        rem_sh = {r_rem, r_quot[DW-1]};
        ge     = rem_sh >= {1'b0, r_div};
        diff   = rem_sh - {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(DW);
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = ge ? diff[SW-1:0] : rem_sh[SW-1:0];
            n_quot = {r_quot[DW-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ----- sv/hwt_datapath.sv -----
// ----------------------------------------------------------------------------
// Hashed timing wheel datapath
// Entry table, wheel position, configuration and the result register.
// ----------------------------------------------------------------------------
module hwt_datapath #(
    parameter int ID_COUNT = hwt_pkg::ID_MAX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hwt_pkg::t_cmd                  i_cmd,
    output hwt_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [hwt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hwt_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [1:0]                     i_func,
    input  logic [hwt_pkg::ID_W-1:0]       i_event_id,
    input  logic [hwt_pkg::DELAY_W-1:0]    i_interval,
    input  logic                           i_recurring,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_kind,
    output logic [hwt_pkg::ID_W-1:0]       o_result_id,
    output logic [2:0]                     o_status,
    output logic                           o_last
);
    localparam int IW   = hwt_pkg::ID_W;
    localparam int SW   = hwt_pkg::SLOT_W;
    localparam int RW   = hwt_pkg::ROUND_W;
    localparam int DLW  = hwt_pkg::DELAY_W;
    localparam int DW   = hwt_pkg::DIV_W;
    localparam int IDXW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

    logic [SW-1:0]       r_slots;
    logic [RW-1:0]       r_limit;
    logic [1:0]          r_func;
    logic [IW-1:0]       r_event_id;
    logic [DLW-1:0]      r_interval;
    logic                r_recurring;
    logic [ID_COUNT-1:0] r_valid;
    logic [ID_COUNT-1:0] r_mask;
    logic                r_repeat [ID_COUNT];
    logic [DLW-1:0]      r_delay  [ID_COUNT];
    logic [SW-1:0]       r_slot   [ID_COUNT];
    logic [RW-1:0]       r_round  [ID_COUNT];
    logic [SW-1:0]       r_cur_slot;
    logic [RW-1:0]       r_cur_round;
    logic [IW-1:0]       r_wr_id;
    logic                r_out_valid;
    logic [1:0]          r_kind;
    logic [IW-1:0]       r_result_id;
    logic [2:0]          r_status;
    logic                r_last;

    logic [SW-1:0]       slot_count;
    logic [IW-1:0]       alloc_id;
    logic [IW-1:0]       scan_id;
    logic [ID_COUNT-1:0] mask_now;
    logic [ID_COUNT-1:0] scan_bit;
    logic [DW-1:0]       dividend;
    logic                div_done;
    logic [DW-1:0]       div_quot;
    logic [SW-1:0]       div_rem;
    logic [SW:0]         slot_inc;
    logic                out_free;
    logic [1:0]          rp_kind;
    logic [IW-1:0]       rp_id;
    logic [2:0]          rp_status;

    assign slot_count = (r_slots == '0) ? SW'(1) : r_slots;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        alloc_id = '0;
        scan_id  = '0;
        for (int i = ID_COUNT - 1; i >= 0; i--) begin
            if (!r_valid[i]) alloc_id = IW'(i);
            if (r_mask[i])   scan_id  = IW'(i);
        end
        for (int i = 0; i < ID_COUNT; i++) begin
            mask_now[i] = r_valid[i] && (r_slot[i] == r_cur_slot) && (r_round[i] <= r_cur_round);
        end
        scan_bit = '0;
        scan_bit[scan_id[IDXW-1:0]] = 1'b1;
    end

    assign dividend = DW'(r_cur_slot) +
                      (i_cmd.div_tick ? DW'(r_delay[scan_id[IDXW-1:0]]) : DW'(r_interval));
    assign slot_inc = {1'b0, r_cur_slot} + 1'b1;

    hwt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (slot_count),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        rp_kind   = hwt_pkg::KIND_REG;
        rp_id     = '0;
        rp_status = hwt_pkg::ST_OK;
        unique case (i_cmd.reply)
            hwt_pkg::RP_REG_OK:  rp_id = r_wr_id;
            hwt_pkg::RP_FULL:    rp_status = hwt_pkg::ST_FULL;
            hwt_pkg::RP_ZERO:    rp_status = hwt_pkg::ST_ZERO;
            hwt_pkg::RP_STOP: begin
                rp_kind   = hwt_pkg::KIND_TICK;
                rp_status = hwt_pkg::ST_STOP;
            end
            hwt_pkg::RP_QUIET:   rp_kind = hwt_pkg::KIND_TICK;
            hwt_pkg::RP_CAN_OK: begin
                rp_kind = hwt_pkg::KIND_CANCEL;
                rp_id   = r_event_id;
            end
            hwt_pkg::RP_CAN_BAD: begin
                rp_kind   = hwt_pkg::KIND_CANCEL;
                rp_id     = r_event_id;
                rp_status = hwt_pkg::ST_INACTIVE;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.func        = r_func;
        o_sts.zero_int    = r_interval == '0;
        o_sts.full        = &r_valid;
        o_sts.stopped     = (r_limit != '0) && (r_cur_round >= r_limit);
        o_sts.cancel_ok   = ({1'b0, r_event_id} < (IW + 1)'(ID_COUNT)) &&
                            r_valid[r_event_id[IDXW-1:0]];
        o_sts.mask_empty  = r_mask == '0;
        o_sts.scan_repeat = r_repeat[scan_id[IDXW-1:0]];
        o_sts.div_done    = div_done;
        o_sts.out_free    = out_free;
    end

    // Control state: configuration, valid bits, match mask, wheel position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= SW'(8);
            r_limit     <= '0;
            r_valid     <= '0;
            r_mask      <= '0;
            r_cur_slot  <= '0;
            r_cur_round <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == hwt_pkg::CFG_SLOTS) r_slots <= i_cfg_data[SW-1:0];
                if (i_cfg_idx == hwt_pkg::CFG_LIMIT) r_limit <= i_cfg_data[RW-1:0];
            end
            if (i_cmd.commit && i_cmd.commit_alloc) r_valid[r_wr_id[IDXW-1:0]] <= 1'b1;
            if (i_cmd.cancel_clr) r_valid[r_event_id[IDXW-1:0]] <= 1'b0;
            if (i_cmd.load_mask) r_mask <= mask_now;
            if (i_cmd.fire) begin
                r_mask <= r_mask & ~scan_bit;
                if (!r_repeat[scan_id[IDXW-1:0]]) r_valid[scan_id[IDXW-1:0]] <= 1'b0;
            end
            if (i_cmd.advance) begin
                if (slot_inc >= {1'b0, slot_count}) begin
                    r_cur_slot  <= '0;
                    r_cur_round <= r_cur_round + 1'b1;
                end else begin
                    r_cur_slot <= slot_inc[SW-1:0];
                end
            end
            if (i_cmd.emit_reply || i_cmd.fire) r_out_valid <= 1'b1;
            else if (!i_out_stall)              r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func      <= i_func;
            r_event_id  <= i_event_id;
            r_interval  <= i_interval;
            r_recurring <= i_recurring;
        end
        if (i_cmd.div_start) r_wr_id <= i_cmd.div_tick ? scan_id : alloc_id;
        if (i_cmd.commit) begin
            r_slot[r_wr_id[IDXW-1:0]]  <= div_rem;
            r_round[r_wr_id[IDXW-1:0]] <= r_cur_round + RW'(div_quot);
            if (i_cmd.commit_alloc) begin
                r_repeat[r_wr_id[IDXW-1:0]] <= r_recurring;
                r_delay[r_wr_id[IDXW-1:0]]  <= r_interval;
            end
        end
        if (i_cmd.emit_reply) begin
            r_kind      <= rp_kind;
            r_result_id <= rp_id;
            r_status    <= rp_status;
            r_last      <= 1'b1;
        end else if (i_cmd.fire) begin
            r_kind      <= hwt_pkg::KIND_FIRE;
            r_result_id <= scan_id;
            r_status    <= hwt_pkg::ST_OK;
            r_last      <= (r_mask & ~scan_bit) == '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_result_id = r_result_id;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

// ----- sv/hwt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Hashed timing wheel controller
// Sequences decode, division, entry scan and result emission for one item.
// ----------------------------------------------------------------------------
module hwt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hwt_pkg::t_sts  i_sts,
    output hwt_pkg::t_cmd  o_cmd
);
    hwt_pkg::t_state r_state, n_state;
    hwt_pkg::t_reply r_reply, n_reply;
    logic            r_fired, n_fired;

    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        n_fired = r_fired;
        unique case (r_state)
            hwt_pkg::S_IDLE: if (i_in_valid) n_state = hwt_pkg::S_DEC;
            hwt_pkg::S_DEC: begin
                case (i_sts.func)
                    hwt_pkg::FUNC_REG: begin
                        if (i_sts.zero_int) begin
                            n_reply = hwt_pkg::RP_ZERO;
                            n_state = hwt_pkg::S_EMIT;
                        end else if (i_sts.full) begin
                            n_reply = hwt_pkg::RP_FULL;
                            n_state = hwt_pkg::S_EMIT;
                        end else begin
                            n_state = hwt_pkg::S_DIV;
                        end
                    end
                    hwt_pkg::FUNC_CANCEL: begin
                        n_reply = i_sts.cancel_ok ? hwt_pkg::RP_CAN_OK : hwt_pkg::RP_CAN_BAD;
                        n_state = hwt_pkg::S_EMIT;
                    end
                    hwt_pkg::FUNC_TICK: begin
                        n_fired = 1'b0;
                        if (i_sts.stopped) begin
                            n_reply = hwt_pkg::RP_STOP;
                            n_state = hwt_pkg::S_EMIT;
                        end else begin
                            n_state = hwt_pkg::S_SCAN;
                        end
                    end
                    default: n_state = hwt_pkg::S_IDLE;
                endcase
            end
            hwt_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.func == hwt_pkg::FUNC_REG) begin
                        n_reply = hwt_pkg::RP_REG_OK;
                        n_state = hwt_pkg::S_EMIT;
                    end else begin
                        n_state = hwt_pkg::S_SCAN;
                    end
                end
            end
            hwt_pkg::S_EMIT: if (i_sts.out_free) n_state = hwt_pkg::S_IDLE;
            hwt_pkg::S_SCAN: begin
                if (i_sts.mask_empty) begin
                    if (r_fired || i_sts.out_free) n_state = hwt_pkg::S_IDLE;
                end else if (i_sts.out_free) begin
                    n_fired = 1'b1;
                    if (i_sts.scan_repeat) n_state = hwt_pkg::S_DIV;
                end
            end
            default: n_state = hwt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.reply = (r_state == hwt_pkg::S_SCAN) ? hwt_pkg::RP_QUIET : r_reply;
        o_in_stall  = r_state != hwt_pkg::S_IDLE;
        unique case (r_state)
            hwt_pkg::S_IDLE: o_cmd.latch_in = i_in_valid;
            hwt_pkg::S_DEC: begin
                case (i_sts.func)
                    hwt_pkg::FUNC_REG:    o_cmd.div_start  = !i_sts.zero_int && !i_sts.full;
                    hwt_pkg::FUNC_CANCEL: o_cmd.cancel_clr = i_sts.cancel_ok;
                    hwt_pkg::FUNC_TICK:   o_cmd.load_mask  = !i_sts.stopped;
                    default: ;
                endcase
            end
            hwt_pkg::S_DIV: begin
                o_cmd.commit       = i_sts.div_done;
                o_cmd.commit_alloc = i_sts.func == hwt_pkg::FUNC_REG;
            end
            hwt_pkg::S_EMIT: o_cmd.emit_reply = i_sts.out_free;
            hwt_pkg::S_SCAN: begin
                if (i_sts.mask_empty) begin
                    // The wheel moves only after every due entry is fired and rescheduled.
                    o_cmd.advance    = r_fired || i_sts.out_free;
                    o_cmd.emit_reply = !r_fired && i_sts.out_free;
                end else if (i_sts.out_free) begin
                    o_cmd.fire      = 1'b1;
                    o_cmd.div_start = i_sts.scan_repeat;
                    o_cmd.div_tick  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hwt_pkg::S_IDLE;
            r_reply <= hwt_pkg::RP_QUIET;
            r_fired <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
            r_fired <= n_fired;
        end
    end

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> r_state == hwt_pkg::S_DIV)
        else $error("divider finished outside the divide state");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_reply || o_cmd.fire) |-> i_sts.out_free)
        else $error("result written while the output register is held");
    a_idle_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hwt_pkg::S_IDLE |-> i_sts.mask_empty)
        else $error("due entries left behind after a tick");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == hwt_pkg::S_DIV)
        else $error("division started without waiting for it");
`endif

endmodule

// ----- sv/hashed_timing_wheel_top.sv -----
// Flow: a cancel, a rejected register or a stopped tick is decoded and its result written to
// the output register; an accepted register first goes through the restoring divider, which
// places the entry. A tick scans the due entries and fires them one by one, and divides each
// recurring event again to reschedule it. One item is worked at a time; the next is taken once
// the last result is in the output register. Output stalls hold up the emit and scan states.
// Synchronous active-low reset clears all entries and the wheel.
// ----------------------------------------------------------------------------
// Hashed timing wheel top level
// Event table on a slotted wheel with register, cancel and tick operations.
// ----------------------------------------------------------------------------
module hashed_timing_wheel_top #(
    parameter int MAX_EVENTS = hwt_pkg::MAX_EVENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hwt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hwt_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [hwt_pkg::ID_W-1:0]       i_event_id,
    input  logic [hwt_pkg::DELAY_W-1:0]    i_interval,
    input  logic                           i_recurring,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_kind,
    output logic [hwt_pkg::ID_W-1:0]       o_result_id,
    output logic [2:0]                     o_status,
    output logic                           o_last
);
    localparam int ID_COUNT = (MAX_EVENTS < hwt_pkg::ID_MAX) ? MAX_EVENTS : hwt_pkg::ID_MAX;

    hwt_pkg::t_cmd cmd;
    hwt_pkg::t_sts sts;

    hwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hwt_datapath #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_event_id  (i_event_id),
        .i_interval  (i_interval),
        .i_recurring (i_recurring),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_result_id (o_result_id),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
